// ----- design/ecbc_pkg.sv -----
// Package for the frame bottleneck classifier: types, register codes and constants.
// Used by the top level, the lanes and the merging stage; depends on nothing.
package ecbc_pkg;

    localparam int NUM_AVG      = 7;
    localparam int HINT_CAP     = 16;
    localparam int FULL_PERCENT = 25600;

    // Lane order of the averages.
    localparam int LANE_GPU  = 0;
    localparam int LANE_ALU  = 1;
    localparam int LANE_TEX  = 2;
    localparam int LANE_BW   = 3;
    localparam int LANE_THIT = 4;
    localparam int LANE_L1   = 5;
    localparam int LANE_L2   = 6;

    // Cache efficiency weights in Q0.16.
    localparam logic [15:0] W_TEX = 16'd32768;
    localparam logic [15:0] W_L1  = 16'd19661;
    localparam logic [15:0] W_L2  = 16'd13107;

    typedef enum logic [2:0] {
        CFG_ALPHA     = 3'd0,
        CFG_GPU_LOW   = 3'd1,
        CFG_BW_HIGH   = 3'd2,
        CFG_ALU_HIGH  = 3'd3,
        CFG_THIT_LOW  = 3'd4,
        CFG_DRAW_HIGH = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_CPU  = 2'd1,
        K_BW   = 2'd2,
        K_ALU  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_CLS
    } t_state;

    typedef struct packed {
        logic load;
        logic update;
    } t_lane_ctrl;

    typedef struct packed {
        logic [15:0] alpha;
        logic [14:0] gpu_low;
        logic [14:0] bw_high;
        logic [14:0] alu_high;
        logic [15:0] thit_low;
        logic [23:0] draw_high;
    } t_cfg;

    typedef logic [NUM_AVG-1:0][15:0] t_avg_array;

    typedef struct packed {
        t_kind       kind;
        logic [14:0] score;
        logic [7:0]  hints;
        logic [2:0]  total;
        logic [15:0] eff;
        logic [14:0] bw_press;
        logic [31:0] frames;
    } t_result;

endpackage

// ----- design/perf_counter_ema_bottleneck_classifier_unit.sv -----
// Top level of the frame bottleneck classifier: control, configuration registers, lanes, output.
// Depends on ecbc_pkg, ecbc_ema_lane and ecbc_classify.
//
// Usage. One frame's counter sample is a transfer on the input channel
// (i_in_valid, o_in_stall). Seven lanes each move one moving average toward
// its sample, and the merging stage classifies the bottleneck from the new
// averages. One result per sample is a transfer on the output channel
// (o_out_valid, i_out_stall).
// Steps: the lane multiply is registered when a sample is accepted, then the
// lane update, then the classify step, which loads the output register once it
// is free; the block works on one sample at a time.
// While the receiver stalls, the result holds in the output register. A new
// sample is still accepted and processed; it waits in the classify step until
// the output register is free.
// Configuration: (i_cfg_valid, o_cfg_ready) is always ready; write only while
// the block is idle. Unknown register indexes are ignored.
// Reset: synchronous, active low. It restores the default registers, clears
// all averages and the frame count, and empties the output register.
module perf_counter_ema_bottleneck_classifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [14:0] i_gpu_util,
    input  logic [14:0] i_alu_util,
    input  logic [14:0] i_texture_util,
    input  logic [14:0] i_bandwidth_util,
    input  logic [15:0] i_texture_hit,
    input  logic [15:0] i_first_level_hit,
    input  logic [15:0] i_second_level_hit,
    input  logic [23:0] i_draw_calls,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_bottleneck_kind,
    output logic [14:0] o_confidence_score,
    output logic [7:0]  o_hint_mask,
    output logic [2:0]  o_hint_total,
    output logic [15:0] o_cache_quality,
    output logic [14:0] o_bandwidth_pressure,
    output logic [31:0] o_frames_seen,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import ecbc_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_cfg        r_cfg;
    logic [31:0] r_frames;
    logic [23:0] r_draws;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_res;
    t_lane_ctrl  w_ctrl;
    logic        w_accept;
    logic        w_out_free;
    logic        w_out_load;
    t_avg_array  w_avg;
    logic [NUM_AVG-1:0][15:0] w_sample;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sample fields in lane order, percentages zero-extended to 16 bits.
    assign w_sample[LANE_GPU]  = {1'b0, i_gpu_util};
    assign w_sample[LANE_ALU]  = {1'b0, i_alu_util};
    assign w_sample[LANE_TEX]  = {1'b0, i_texture_util};
    assign w_sample[LANE_BW]   = {1'b0, i_bandwidth_util};
    assign w_sample[LANE_THIT] = i_texture_hit;
    assign w_sample[LANE_L1]   = i_first_level_hit;
    assign w_sample[LANE_L2]   = i_second_level_hit;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_CLS;
            end
            S_CLS: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall    = 1'b1;
        w_ctrl.load   = 1'b0;
        w_ctrl.update = 1'b0;
        w_out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                w_ctrl.load = i_in_valid;
            end
            S_UPD: begin
                w_ctrl.update = 1'b1;
            end
            S_CLS: begin
                w_out_load = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha     <= 16'd6554;
            r_cfg.gpu_low   <= 15'd17920;
            r_cfg.bw_high   <= 15'd21760;
            r_cfg.alu_high  <= 15'd23040;
            r_cfg.thit_low  <= 16'd27853;
            r_cfg.draw_high <= 24'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ALPHA:     r_cfg.alpha     <= i_cfg_data[15:0];
                CFG_GPU_LOW:   r_cfg.gpu_low   <= i_cfg_data[14:0];
                CFG_BW_HIGH:   r_cfg.bw_high   <= i_cfg_data[14:0];
                CFG_ALU_HIGH:  r_cfg.alu_high  <= i_cfg_data[14:0];
                CFG_THIT_LOW:  r_cfg.thit_low  <= i_cfg_data[15:0];
                CFG_DRAW_HIGH: r_cfg.draw_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The draw-call hint uses this frame's count, not an average.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_draws <= i_draw_calls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
        end else if (w_ctrl.update) begin
            r_frames <= r_frames + 32'd1;
        end
    end

    // Seven lanes, one per averaged counter.
    for (genvar g = 0; g < NUM_AVG; g++) begin : g_lane
        ecbc_ema_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_alpha  (r_cfg.alpha),
            .i_sample (w_sample[g]),
            .o_avg    (w_avg[g])
        );
    end

    ecbc_classify u_classify (
        .i_avg    (w_avg),
        .i_cfg    (r_cfg),
        .i_draws  (r_draws),
        .i_frames (r_frames),
        .o_res    (w_res)
    );

    // Output register: it holds a result for as long as the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_bottleneck_kind    = 2'(r_out.kind);
    assign o_confidence_score   = r_out.score;
    assign o_hint_mask          = r_out.hints;
    assign o_hint_total         = r_out.total;
    assign o_cache_quality      = r_out.eff;
    assign o_bandwidth_pressure = r_out.bw_press;
    assign o_frames_seen        = r_out.frames;

endmodule

// ----- design/ecbc_ema_lane.sv -----
// One moving-average lane: multiplies alpha by the distance to the sample, then steps the average.
// Depends on ecbc_pkg.
module ecbc_ema_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ecbc_pkg::t_lane_ctrl i_ctrl,
    input  logic [15:0]          i_alpha,
    input  logic [15:0]          i_sample,
    output logic [15:0]          o_avg
);
    import ecbc_pkg::*;

    logic [15:0] r_avg;
    logic [15:0] n_avg;
    logic [31:0] r_prod;
    logic        r_rise;
    logic        w_rise;
    logic [15:0] w_diff;
    logic [16:0] w_step;

    always_comb begin
        w_rise = (i_sample >= r_avg);
        w_diff = w_rise ? (i_sample - r_avg) : (r_avg - i_sample);
        // Round to nearest, ties away from zero, on the magnitude.
        w_step = 17'(({1'b0, r_prod} + 33'd32768) >> 16);
        n_avg  = r_rise ? (r_avg + w_step[15:0]) : (r_avg - w_step[15:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod <= i_alpha * w_diff;
            r_rise <= w_rise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (i_ctrl.update) begin
            r_avg <= n_avg;
        end
    end

    assign o_avg = r_avg;

endmodule

// ----- design/ecbc_classify.sv -----
// Merging stage: scores the bottleneck candidates, raises hints and weighs cache efficiency.
// Depends on ecbc_pkg.
module ecbc_classify (
    input  ecbc_pkg::t_avg_array i_avg,
    input  ecbc_pkg::t_cfg       i_cfg,
    input  logic [23:0]          i_draws,
    input  logic [31:0]          i_frames,
    output ecbc_pkg::t_result    o_res
);
    import ecbc_pkg::*;

    logic [15:0] w_gpu;
    logic [15:0] w_alu;
    logic [15:0] w_bw;
    logic [14:0] w_best;
    logic [14:0] w_cand;
    t_kind       w_kind;
    logic [7:0]  w_mask;
    logic [2:0]  w_cnt;
    logic [2:0]  w_base;
    logic [33:0] w_sum;
    logic [17:0] w_eff;

    always_comb begin
        w_gpu  = i_avg[LANE_GPU];
        w_alu  = i_avg[LANE_ALU];
        w_bw   = i_avg[LANE_BW];
        w_best = '0;
        w_kind = K_NONE;
        w_cand = '0;

        // Candidates in fixed order; only a strictly greater score takes over.
        if (w_gpu < {1'b0, i_cfg.gpu_low}) begin
            w_cand = (w_gpu < 16'(FULL_PERCENT)) ? 15'(16'(FULL_PERCENT) - w_gpu) : '0;
            if (w_cand > w_best) begin
                w_best = w_cand;
                w_kind = K_CPU;
            end
        end
        if (w_bw > {1'b0, i_cfg.bw_high}) begin
            w_cand = w_bw[15] ? 15'h7fff : w_bw[14:0];
            if (w_cand > w_best) begin
                w_best = w_cand;
                w_kind = K_BW;
            end
        end
        if (w_alu > {1'b0, i_cfg.alu_high}) begin
            w_cand = w_alu[15] ? 15'h7fff : w_alu[14:0];
            if (w_cand > w_best) begin
                w_best = w_cand;
                w_kind = K_ALU;
            end
        end

        w_mask = '0;
        w_cnt  = '0;
        w_base = {2'(w_kind) - 2'd1, 1'b0};
        if (w_kind != K_NONE) begin
            if (int'(w_cnt) < HINT_CAP) begin
                w_mask[w_base] = 1'b1;
                w_cnt          = w_cnt + 3'd1;
            end
            if (int'(w_cnt) < HINT_CAP) begin
                w_mask[w_base + 3'd1] = 1'b1;
                w_cnt                 = w_cnt + 3'd1;
            end
        end
        if ((i_avg[LANE_THIT] < i_cfg.thit_low) && (int'(w_cnt) < HINT_CAP)) begin
            w_mask[6] = 1'b1;
            w_cnt     = w_cnt + 3'd1;
        end
        if ((i_draws > i_cfg.draw_high) && (int'(w_cnt) < HINT_CAP)) begin
            w_mask[7] = 1'b1;
            w_cnt     = w_cnt + 3'd1;
        end

        w_sum = 34'(i_avg[LANE_THIT]) * 34'(W_TEX) + 34'(i_avg[LANE_L1]) * 34'(W_L1)
              + 34'(i_avg[LANE_L2]) * 34'(W_L2) + 34'd32768;
        w_eff = w_sum[33:16];

        o_res.kind     = w_kind;
        o_res.score    = w_best;
        o_res.hints    = w_mask;
        o_res.total    = w_cnt;
        o_res.eff      = (w_eff > 18'd65535) ? 16'hffff : w_eff[15:0];
        o_res.bw_press = w_bw[15] ? 15'h7fff : w_bw[14:0];
        o_res.frames   = i_frames;
    end

endmodule

// ----- design/ecbc_checker.sv -----
// Port-level checker for the frame bottleneck classifier, bound to the top level.
// Depends on perf_counter_ema_bottleneck_classifier_unit.
module ecbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_bottleneck_kind,
    input logic [14:0] o_confidence_score,
    input logic [7:0]  o_hint_mask,
    input logic [2:0]  o_hint_total,
    input logic [31:0] o_frames_seen
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result stays valid and holds its frame count, hint mask and score.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frames_seen)
            && $stable(o_hint_mask) && $stable(o_confidence_score))
        else $error("stalled result changed");

    // One sample at a time: an accepted sample blocks the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // No bottleneck means a zero score and no bottleneck hints.
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_bottleneck_kind == 2'd0)
            |-> (o_confidence_score == 15'd0) && (o_hint_mask[5:0] == 6'd0))
        else $error("no bottleneck with score or hints");

    // The hint count agrees with the hint bits.
    a_hint_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_hint_mask) == 32'(o_hint_total)))
        else $error("hint count mismatch");

endmodule

bind perf_counter_ema_bottleneck_classifier_unit ecbc_checker u_ecbc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_bottleneck_kind  (o_bottleneck_kind),
    .o_confidence_score (o_confidence_score),
    .o_hint_mask        (o_hint_mask),
    .o_hint_total       (o_hint_total),
    .o_frames_seen      (o_frames_seen)
);

// ----- bench/tb_perf_counter_ema_bottleneck_classifier_unit.sv -----
// Self-checking bench for the frame bottleneck classifier: it drives counter samples,
// predicts every verdict in its own model and checks each output transfer field by field.
// Depends on ecbc_pkg and perf_counter_ema_bottleneck_classifier_unit.
`timescale 1ns / 1ps

module tb_perf_counter_ema_bottleneck_classifier_unit;
    import ecbc_pkg::*;

    // Register indexes that the block does not decode. Writes to them must be ignored.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Roughly 500 samples, even in the worst phase, fit many times over into this
    // bound.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // One frame's counter sample as it appears on the input ports.
    typedef struct packed {
        logic [14:0] gpu;
        logic [14:0] alu;
        logic [14:0] tex;
        logic [14:0] bw;
        logic [15:0] thit;
        logic [15:0] l1;
        logic [15:0] l2;
        logic [23:0] draws;
    } t_frame;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [14:0] i_gpu_util = '0;
    logic [14:0] i_alu_util = '0;
    logic [14:0] i_texture_util = '0;
    logic [14:0] i_bandwidth_util = '0;
    logic [15:0] i_texture_hit = '0;
    logic [15:0] i_first_level_hit = '0;
    logic [15:0] i_second_level_hit = '0;
    logic [23:0] i_draw_calls = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_bottleneck_kind;
    logic [14:0] o_confidence_score;
    logic [7:0]  o_hint_mask;
    logic [2:0]  o_hint_total;
    logic [15:0] o_cache_quality;
    logic [14:0] o_bandwidth_pressure;
    logic [31:0] o_frames_seen;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_ALPHA;
    logic [23:0] i_cfg_data = '0;

    perf_counter_ema_bottleneck_classifier_unit u_top (.*);

    always #1 i_clk = ~i_clk;

    // Samples waiting to be driven, and the verdicts predicted for accepted samples.
    t_frame      queued_frames[$];
    t_result     predicted_verdicts[$];
    t_frame      frame_on_bus;

    // Idling mix of the current phase, in percent of cycles.
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct = 0;

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // The model's own copy of the registers and of the running state.
    t_cfg        model_cfg;
    logic [15:0] lane_avg [NUM_AVG];
    logic [31:0] frame_count;

    task automatic flag_error(input string what, input longint unsigned got,
                              input longint unsigned want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [14:0] sat15(input int unsigned v);
        return (v > 32767) ? 15'h7FFF : v[14:0];
    endfunction

    // One moving-average step: avg + alpha*(x-avg), where the step is rounded to
    // nearest with ties away from zero. The result always lies between avg and x.
    function automatic logic [15:0] ema_move(input logic [15:0] avg, input logic [15:0] x);
        logic [33:0] prod;
        if (x >= avg) begin
            prod = model_cfg.alpha * (x - avg) + 34'd32768;
            return avg + prod[31:16];
        end else begin
            prod = model_cfg.alpha * (avg - x) + 34'd32768;
            return avg - prod[31:16];
        end
    endfunction

    // Moves all seven averages toward the sample, then classifies the bottleneck
    // from the new averages and builds the verdict the block must report.
    function automatic t_result classify_frame(input t_frame f);
        logic [15:0] lane_in [NUM_AVG];
        logic [15:0] gpu;
        logic [15:0] alu;
        logic [15:0] bw;
        logic [7:0]  want;
        logic [33:0] acc;
        int unsigned best;
        int unsigned s;
        int unsigned kept;
        t_kind       kind;
        t_result     r;

        lane_in[LANE_GPU]  = {1'b0, f.gpu};
        lane_in[LANE_ALU]  = {1'b0, f.alu};
        lane_in[LANE_TEX]  = {1'b0, f.tex};
        lane_in[LANE_BW]   = {1'b0, f.bw};
        lane_in[LANE_THIT] = f.thit;
        lane_in[LANE_L1]   = f.l1;
        lane_in[LANE_L2]   = f.l2;
        for (int i = 0; i < NUM_AVG; i++) begin
            lane_avg[i] = ema_move(lane_avg[i], lane_in[i]);
        end
        frame_count = frame_count + 32'd1;

        gpu = lane_avg[LANE_GPU];
        alu = lane_avg[LANE_ALU];
        bw  = lane_avg[LANE_BW];

        // Candidates in the order CPU, bandwidth, ALU; only a strictly greater
        // score takes over, so ties go to the earlier candidate and 0 never wins.
        best = 0;
        kind = K_NONE;
        if (gpu < {1'b0, model_cfg.gpu_low}) begin
            s = (gpu < FULL_PERCENT) ? FULL_PERCENT - gpu : 0;
            s = sat15(s);
            if (s > best) begin
                best = s;
                kind = K_CPU;
            end
        end
        if (bw > {1'b0, model_cfg.bw_high}) begin
            s = sat15(bw);
            if (s > best) begin
                best = s;
                kind = K_BW;
            end
        end
        if (alu > {1'b0, model_cfg.alu_high}) begin
            s = sat15(alu);
            if (s > best) begin
                best = s;
                kind = K_ALU;
            end
        end

        // Hint bits are raised in ascending bit order, and the cap keeps the lowest
        // ones.
        want = '0;
        case (kind)
            K_CPU: want[1:0] = 2'b11;
            K_BW:  want[3:2] = 2'b11;
            K_ALU: want[5:4] = 2'b11;
            default: ;
        endcase
        if (lane_avg[LANE_THIT] < model_cfg.thit_low) want[6] = 1'b1;
        if (f.draws > model_cfg.draw_high) want[7] = 1'b1;
        r.hints = '0;
        kept = 0;
        for (int p = 0; p < 8; p++) begin
            if (want[p] && kept < HINT_CAP) begin
                r.hints[p] = 1'b1;
                kept++;
            end
        end

        acc = lane_avg[LANE_THIT] * W_TEX + lane_avg[LANE_L1] * W_L1
            + lane_avg[LANE_L2] * W_L2 + 34'd32768;
        acc = acc >> 16;

        r.kind     = kind;
        r.score    = best[14:0];
        r.total    = kept[2:0];
        r.eff      = (acc > 34'd65535) ? 16'hFFFF : acc[15:0];
        r.bw_press = sat15(bw);
        r.frames   = frame_count;
        return r;
    endfunction

    // Register file and running state as they are after reset.
    task automatic model_reset();
        model_cfg.alpha     = 16'd6554;
        model_cfg.gpu_low   = 15'd17920;
        model_cfg.bw_high   = 15'd21760;
        model_cfg.alu_high  = 15'd23040;
        model_cfg.thit_low  = 16'd27853;
        model_cfg.draw_high = 24'd1000;
        for (int i = 0; i < NUM_AVG; i++) begin
            lane_avg[i] = '0;
        end
        frame_count = '0;
    endtask

    // One register write. The model takes the value, masked to the register's
    // width, at the edge where the transfer happens.
    task automatic write_reg(input logic [2:0] idx, input int unsigned data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[23:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ALPHA:     model_cfg.alpha     = data[15:0];
            CFG_GPU_LOW:   model_cfg.gpu_low   = data[14:0];
            CFG_BW_HIGH:   model_cfg.bw_high   = data[14:0];
            CFG_ALU_HIGH:  model_cfg.alu_high  = data[14:0];
            CFG_THIT_LOW:  model_cfg.thit_low  = data[15:0];
            CFG_DRAW_HIGH: model_cfg.draw_high = data[23:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned alpha, input int unsigned gpu_low,
                              input int unsigned bw_high, input int unsigned alu_high,
                              input int unsigned thit_low, input int unsigned draw_high);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_GPU_LOW, gpu_low);
        write_reg(CFG_BW_HIGH, bw_high);
        write_reg(CFG_ALU_HIGH, alu_high);
        write_reg(CFG_THIT_LOW, thit_low);
        write_reg(CFG_DRAW_HIGH, draw_high);
    endtask

    // Phases start at a falling edge so that the driver never sees the queue
    // change in the same time step as it pops from it.
    task automatic begin_phase(input int unsigned idle_pct, input int unsigned hold_pct);
        @(negedge i_clk);
        sender_idle_pct = idle_pct;
        stall_pct = hold_pct;
    endtask

    task automatic push_frame(input int unsigned g, input int unsigned a, input int unsigned t,
                              input int unsigned b, input int unsigned th,
                              input int unsigned l1, input int unsigned l2,
                              input int unsigned d);
        t_frame f;
        f.gpu   = g[14:0];
        f.alu   = a[14:0];
        f.tex   = t[14:0];
        f.bw    = b[14:0];
        f.thit  = th[15:0];
        f.l1    = l1[15:0];
        f.l2    = l2[15:0];
        f.draws = d[23:0];
        queued_frames.push_back(f);
    endtask

    // Waits until every sample is accepted and every verdict has arrived, then
    // lets the pipeline settle before any register is touched.
    task automatic drain();
        @(negedge i_clk);
        while (queued_frames.size() != 0 || i_in_valid || predicted_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // A level for one field: mostly low, middle or high within the nominal range,
    // sometimes exactly full scale and sometimes anywhere in the port's width.
    function automatic int unsigned pick_level(input int unsigned top,
                                               input int unsigned field_max);
        case ($urandom_range(9))
            0, 1:    return $urandom_range(top / 8);
            2, 3:    return $urandom_range(top / 4, top / 2 + top / 4);
            4, 5, 6: return $urandom_range(top - top / 4, top);
            7:       return top;
            default: return $urandom_range(field_max);
        endcase
    endfunction

    // Draw-call counts are sometimes one below, at or one above the current limit, so that the hint flips.
    function automatic int unsigned pick_draws();
        longint x;
        case ($urandom_range(4))
            0: return 0;
            1: return $urandom_range(2000);
            2: begin
                x = longint'(model_cfg.draw_high) + longint'($urandom_range(2)) - 1;
                if (x < 0) x = 0;
                if (x > 24'hFFFFFF) x = 24'hFFFFFF;
                return int'(x);
            end
            3: return $urandom_range(24'hFFFFFF);
            default: return 24'hFFFFFF;
        endcase
    endfunction

    function automatic int unsigned wobble(input int unsigned centre, input int unsigned span,
                                           input int unsigned limit);
        int x;
        x = int'(centre) + int'($urandom_range(2 * span)) - int'(span);
        if (x < 0) x = 0;
        if (x > int'(limit)) x = limit;
        return x;
    endfunction

    // Random samples come in bursts around a common operating point, so that the
    // averages settle and actually cross the limits. One sample in ten is pure
    // noise over the full port width.
    task automatic make_random_frames(input int count);
        int unsigned base [8];
        int unsigned v [8];
        for (int i = 0; i < count; i++) begin
            if (i % 12 == 0) begin
                for (int k = 0; k < 4; k++) base[k] = pick_level(FULL_PERCENT, 32767);
                for (int k = 4; k < 7; k++) base[k] = pick_level(32768, 65535);
                base[7] = pick_draws();
            end
            if ($urandom_range(9) == 0) begin
                for (int k = 0; k < 4; k++) v[k] = $urandom_range(32767);
                for (int k = 4; k < 7; k++) v[k] = $urandom_range(65535);
                v[7] = $urandom_range(24'hFFFFFF);
            end else begin
                for (int k = 0; k < 4; k++) v[k] = wobble(base[k], 1600, 32767);
                for (int k = 4; k < 7; k++) v[k] = wobble(base[k], 2048, 65535);
                v[7] = ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF) : base[7];
            end
            push_frame(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
        end
    endtask

    // Input driver. A sample stays on the ports until it is taken; the verdict is
    // predicted at the edge where the transfer happens, with the registers as the
    // block holds them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_verdicts.push_back(classify_frame(frame_on_bus));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (queued_frames.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    frame_on_bus = queued_frames.pop_front();
                    i_in_valid         <= 1'b1;
                    i_gpu_util         <= frame_on_bus.gpu;
                    i_alu_util         <= frame_on_bus.alu;
                    i_texture_util     <= frame_on_bus.tex;
                    i_bandwidth_util   <= frame_on_bus.bw;
                    i_texture_hit      <= frame_on_bus.thit;
                    i_first_level_hit  <= frame_on_bus.l1;
                    i_second_level_hit <= frame_on_bus.l2;
                    i_draw_calls       <= frame_on_bus.draws;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver stalls at random, as often as the current phase asks.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Output monitor: every result transfer is matched against the oldest
    // prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_verdicts.size() == 0) begin
                flag_error("result with no sample pending, frames_seen", o_frames_seen, 0);
            end else begin
                want = predicted_verdicts.pop_front();
                if (o_bottleneck_kind != want.kind)
                    flag_error("bottleneck_kind", o_bottleneck_kind, want.kind);
                if (o_confidence_score != want.score)
                    flag_error("confidence_score", o_confidence_score, want.score);
                if (o_hint_mask != want.hints)
                    flag_error("hint_mask", o_hint_mask, want.hints);
                if (o_hint_total != want.total)
                    flag_error("hint_total", o_hint_total, want.total);
                if (o_cache_quality != want.eff)
                    flag_error("cache_quality", o_cache_quality, want.eff);
                if (o_bandwidth_pressure != want.bw_press)
                    flag_error("bandwidth_pressure", o_bandwidth_pressure, want.bw_press);
                if (o_frames_seen != want.frames)
                    flag_error("frames_seen", o_frames_seen, want.frames);
            end
        end
    end

    // Watchdog against a block that hangs.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("perf_counter_ema_bottleneck_classifier_unit regression: fail");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, registers at their reset values: all zero, the draw-call
        // count at and just above its limit, full scale and the port maxima.
        begin_phase(0, 0);
        push_frame(0, 0, 0, 0, 0, 0, 0, 0);
        push_frame(0, 0, 0, 0, 0, 0, 0, 1000);
        push_frame(0, 0, 0, 0, 0, 0, 0, 1001);
        push_frame(25600, 25600, 25600, 25600, 32768, 32768, 32768, 5000);
        push_frame(32767, 32767, 32767, 32767, 65535, 65535, 65535, 24'hFFFFFF);
        drain();

        // Directed, alpha close to one so the averages follow the samples. The
        // GPU limit is written with all data bits set and keeps only 15 of them,
        // so a GPU average above 100% still counts as under the limit but gives
        // a CPU score of zero, which never wins. The spare indexes must not
        // disturb anything.
        set_config(16'hFFFF, 24'hFFFFFF, 21760, 23040, 27853, 1000);
        write_reg(CFG_SPARE_LO, 24'h000000);
        write_reg(CFG_SPARE_HI, 24'hFFFFFF);
        begin_phase(0, 0);
        push_frame(30000, 0, 0, 0, 32768, 32768, 32768, 0);
        push_frame(25600, 0, 0, 0, 32768, 32768, 32768, 0);
        push_frame(10000, 0, 0, 22000, 32768, 32768, 32768, 0);
        push_frame(2000, 0, 0, 22000, 32768, 32768, 32768, 0);
        // Bandwidth and ALU tie: the earlier candidate keeps the win.
        push_frame(25600, 25000, 0, 25000, 32768, 32768, 32768, 0);
        push_frame(25600, 25600, 0, 23000, 32768, 32768, 32768, 0);
        // Both scores saturate and tie again.
        push_frame(25600, 32767, 0, 32767, 32768, 32768, 32768, 0);
        // No bottleneck, but the texture and draw-call hints.
        push_frame(25600, 0, 0, 0, 20000, 32768, 32768, 5000);
        // CPU bound with the texture and draw-call hints raised too.
        push_frame(0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF);
        push_frame(12000, 12000, 12000, 12000, 16384, 16384, 16384, 999);
        drain();

        // Directed, alpha one half: odd differences land exactly on a rounding
        // tie, in both directions.
        set_config(16'h8000, 0, 24'hFFFFFF, 0, 24'hFFFFFF, 24'hFFFFFF);
        begin_phase(0, 0);
        push_frame(0, 1, 0, 0, 1, 1, 1, 0);
        push_frame(0, 2, 0, 3, 3, 5, 7, 24'hFFFFFF);
        push_frame(32767, 32767, 32767, 32767, 65535, 65535, 65535, 24'hFFFFFF);
        push_frame(0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Random phases. Each one rewrites every register, then runs a burst of
        // samples under one of four idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(6554, 17920, 21760, 23040, 27853, 1000);
                1: set_config(16'hFFFF, 0, 0, 0, 32768, 0);
                2: set_config(0, $urandom_range(25600), $urandom_range(25600),
                              $urandom_range(25600), $urandom_range(32768),
                              $urandom_range(3000));
                3: set_config(16384, 25600, 25600, 25600, 0, 24'hFFFFFF);
                4, 5: set_config($urandom_range(16'hFFFF), $urandom_range(25600),
                                 $urandom_range(12800, 25600), $urandom_range(12800, 25600),
                                 $urandom_range(32768), $urandom_range(3000));
                6: set_config($urandom_range(64), $urandom_range(25600),
                              $urandom_range(25600), $urandom_range(25600),
                              $urandom_range(32768), $urandom_range(3000));
                default: set_config($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                                    $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                                    $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF));
            endcase
            write_reg((ph % 2 != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      $urandom_range(24'hFFFFFF));
            case (ph % 4)
                0: begin_phase(0, 0);
                1: begin_phase(84, 0);
                2: begin_phase(0, 84);
                default: begin_phase(13, 13);
            endcase
            make_random_frames(60);
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (predicted_verdicts.size() != 0)
            flag_error("results never delivered", predicted_verdicts.size(), 0);
        if (fail_count == 0) begin
            $display("perf_counter_ema_bottleneck_classifier_unit regression: pass");
        end else begin
            $display("perf_counter_ema_bottleneck_classifier_unit regression: fail");
        end
        $finish;
    end

endmodule
